### rtl/core/can_bts_pkg.sv
package can_bts_pkg;

   // default search and segment limits
   localparam int DEF_MIN_QUANTA     = 8;
   localparam int DEF_MAX_QUANTA     = 25;
   localparam int DEF_MAX_PROP_SEG   = 8;
   localparam int DEF_MIN_PHASE_TWO  = 2;
   localparam int DEF_MAX_JUMP_WIDTH = 4;

   // field and datapath widths
   localparam int CLOCK_WIDTH   = 32;
   localparam int RATE_WIDTH    = 20;
   localparam int QUANTA_WIDTH  = 5;
   localparam int PRES_WIDTH    = 9;
   localparam int DIV_WIDTH     = 32;
   localparam int DIVISOR_WIDTH = 20;

   // largest prescaler the timing register can hold
   localparam logic [DIV_WIDTH-1:0] PRESCALE_LIMIT = DIV_WIDTH'(256);

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_RATIO_GO,
      S_RATIO_WAIT,
      S_PRES_GO,
      S_PRES_WAIT,
      S_CLK_GO,
      S_CLK_WAIT,
      S_ACT_GO,
      S_ACT_WAIT,
      S_NEXT,
      S_REPORT
   } state_type;

   // request to the shared divider
   typedef struct packed {
      logic                     valid;
      logic [DIV_WIDTH-1:0]     dividend;
      logic [DIVISOR_WIDTH-1:0] divisor;
   } div_req_type;

   // answer from the shared divider
   typedef struct packed {
      logic                     done;
      logic [DIV_WIDTH-1:0]     quotient;
      logic [DIVISOR_WIDTH-1:0] remainder;
   } div_rsp_type;

   // result fields of one solve
   typedef struct packed {
      logic       status;
      logic [7:0] prescaler_code;
      logic [1:0] jump_width_code;
      logic [2:0] phase_one_code;
      logic [2:0] phase_two_code;
      logic [2:0] propagation_code;
   } result_type;

endpackage

### rtl/core/can_bts_div.sv
module can_bts_div (
   input  logic                    clock,
   input  logic                    reset,
   input  can_bts_pkg::div_req_type req,
   output can_bts_pkg::div_rsp_type rsp
);

   localparam int DW = can_bts_pkg::DIV_WIDTH;
   localparam int VW = can_bts_pkg::DIVISOR_WIDTH;
   localparam int CW = $clog2(DW + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] divisor_ff, divisor_in;
   logic [VW:0]   trial;
   logic [VW:0]   trial_diff;
   logic          fits;

   // one restoring step: bring down the next dividend bit and try to subtract
   always_comb begin
      trial      = {rem_ff, quo_ff[DW-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});
   end

   // step sequencing, one quotient bit per cycle
   always_comb begin
      run_in     = run_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (req.valid) begin
         run_in     = 1'b1;
         count_in   = CW'(DW);
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (run_ff) begin
         rem_in   = fits ? trial_diff[VW-1:0] : trial[VW-1:0];
         quo_in   = {quo_ff[DW-2:0], fits};
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

### rtl/core/can_bts_seg.sv
module can_bts_seg #(
   parameter int MIN_QUANTA     = can_bts_pkg::DEF_MIN_QUANTA,
   parameter int MAX_PROP_SEG   = can_bts_pkg::DEF_MAX_PROP_SEG,
   parameter int MIN_PHASE_TWO  = can_bts_pkg::DEF_MIN_PHASE_TWO,
   parameter int MAX_JUMP_WIDTH = can_bts_pkg::DEF_MAX_JUMP_WIDTH
) (
   input  logic [can_bts_pkg::QUANTA_WIDTH-1:0] best_t,
   input  logic [can_bts_pkg::PRES_WIDTH-1:0]   best_p,
   output can_bts_pkg::result_type              result
);

   localparam logic signed [6:0] MinQ   = 7'(MIN_QUANTA);
   localparam logic signed [6:0] MaxPro = 7'(MAX_PROP_SEG);
   localparam logic signed [6:0] MinPh2 = 7'(MIN_PHASE_TWO);
   localparam logic signed [6:0] MaxJw  = 7'(MAX_JUMP_WIDTH);
   localparam logic signed [6:0] SegMax = 7'sd8;
   localparam logic signed [6:0] JwMax  = 7'sd4;

   logic signed [6:0] t_s;
   logic signed [6:0] span;
   logic signed [6:0] p1;
   logic signed [6:0] p2;
   logic signed [6:0] prop;
   logic signed [6:0] rjw;
   logic              fail;

   // saturate a length to 1..hi and report it minus one
   function automatic logic [2:0] len_code(input logic signed [6:0] v,
                                           input logic signed [6:0] hi);
      logic signed [6:0] c;
      begin
         c = v;
         if (v < 7'sd1) c = 7'sd1;
         else if (v > hi) c = hi;
         c = c - 7'sd1;
         return c[2:0];
      end
   endfunction

   // segment split for the chosen count
   always_comb begin
      t_s  = signed'({2'b00, best_t});
      span = t_s - MaxPro;
      if (span < 7'sd0) span = 7'sd0;
      p2 = span >>> 1;
      if (p2 < MinPh2) p2 = MinPh2;
      p1   = (t_s == MinQ) ? 7'sd1 : p2;
      prop = t_s - p1 - p2 - 7'sd1;
      rjw  = (p1 < MaxJw) ? p1 : MaxJw;
   end

   // codes, all zero on failure
   always_comb begin
      fail          = (best_t == '0) || (best_p == '0);
      result        = '0;
      result.status = 1'b1;
      if (!fail) begin
         result.status           = 1'b0;
         result.prescaler_code   = 8'(best_p - can_bts_pkg::PRES_WIDTH'(1));
         result.jump_width_code  = 2'(len_code(rjw, JwMax));
         result.phase_one_code   = len_code(p1, SegMax);
         result.phase_two_code   = len_code(p2, SegMax);
         result.propagation_code = len_code(prop, SegMax);
      end
   end

endmodule

### rtl/core/can_bit_timing_solver.sv
// channel   ports                          transfer
// request   start, busy, req_*             start high while busy low
// result    rsp_valid, rsp_*               one cycle with rsp_valid high
//
// a request runs as follows from its transfer to the result:
// a zero bit rate reports at once, otherwise a ratio division comes first,
// then each quanta count from the largest down costs up to three divisions
// on the one shared bit-serial divider plus one step state.
// busy is high from the request transfer and drops as the result shows.
// reset clears the sequencer and the result strobe; the receiver cannot stall.
module can_bit_timing_solver #(
   parameter int MIN_QUANTA     = can_bts_pkg::DEF_MIN_QUANTA,
   parameter int MAX_QUANTA     = can_bts_pkg::DEF_MAX_QUANTA,
   parameter int MAX_PROP_SEG   = can_bts_pkg::DEF_MAX_PROP_SEG,
   parameter int MIN_PHASE_TWO  = can_bts_pkg::DEF_MIN_PHASE_TWO,
   parameter int MAX_JUMP_WIDTH = can_bts_pkg::DEF_MAX_JUMP_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_clock_hz,
   input  logic [19:0] req_bit_rate,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [7:0]  rsp_prescaler_code,
   output logic [1:0]  rsp_jump_width_code,
   output logic [2:0]  rsp_phase_one_code,
   output logic [2:0]  rsp_phase_two_code,
   output logic [2:0]  rsp_propagation_code
);

   localparam int DW = can_bts_pkg::DIV_WIDTH;
   localparam int VW = can_bts_pkg::DIVISOR_WIDTH;
   localparam int RW = can_bts_pkg::RATE_WIDTH;
   localparam int QW = can_bts_pkg::QUANTA_WIDTH;
   localparam int PW = can_bts_pkg::PRES_WIDTH;

   localparam logic [QW-1:0] TMin     = QW'(MIN_QUANTA);
   localparam logic [QW-1:0] TMax     = QW'(MAX_QUANTA);
   localparam logic [DW-1:0] RatioMin = DW'(MIN_QUANTA - 1);
   localparam logic          NoCounts = (MIN_QUANTA > MAX_QUANTA);

   can_bts_pkg::state_type state_ff, state_in;

   logic [DW-1:0] clk_ff, clk_in;
   logic [RW-1:0] rate_ff, rate_in;
   logic [DW-1:0] ratio_ff, ratio_in;
   logic [DW-1:0] clkdiv_ff, clkdiv_in;
   logic [QW-1:0] t_ff, t_in;
   logic [PW-1:0] pres_ff, pres_in;
   logic [RW-1:0] lowest_ff, lowest_in;
   logic [QW-1:0] best_t_ff, best_t_in;
   logic [PW-1:0] best_p_ff, best_p_in;
   logic          rsp_valid_ff, rsp_valid_in;

   can_bts_pkg::result_type  result_ff, result_in;
   can_bts_pkg::result_type  seg_result;
   can_bts_pkg::div_req_type div_req;
   can_bts_pkg::div_rsp_type div_rsp;

   logic [DW-1:0] actual_diff;
   logic          quo_usable;

   // shared divider
   can_bts_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // segment split of the kept count
   can_bts_seg #(
      .MIN_QUANTA     (MIN_QUANTA),
      .MAX_PROP_SEG   (MAX_PROP_SEG),
      .MIN_PHASE_TWO  (MIN_PHASE_TWO),
      .MAX_JUMP_WIDTH (MAX_JUMP_WIDTH)
   ) u_seg (
      .best_t (best_t_ff),
      .best_p (best_p_ff),
      .result (seg_result)
   );

   // distance of the achieved rate and prescaler range check
   always_comb begin
      actual_diff = (div_rsp.quotient > DW'(rate_ff)) ?
                    (div_rsp.quotient - DW'(rate_ff)) : (DW'(rate_ff) - div_rsp.quotient);
      quo_usable  = (div_rsp.quotient != '0) &&
                    (div_rsp.quotient <= can_bts_pkg::PRESCALE_LIMIT);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         can_bts_pkg::S_IDLE: begin
            if (start) begin
               state_in = (req_bit_rate == '0) ? can_bts_pkg::S_REPORT
                                               : can_bts_pkg::S_RATIO_GO;
            end
         end
         can_bts_pkg::S_RATIO_GO:   state_in = can_bts_pkg::S_RATIO_WAIT;
         can_bts_pkg::S_RATIO_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient < RatioMin || NoCounts) begin
                  state_in = can_bts_pkg::S_REPORT;
               end else begin
                  state_in = can_bts_pkg::S_PRES_GO;
               end
            end
         end
         can_bts_pkg::S_PRES_GO:    state_in = can_bts_pkg::S_PRES_WAIT;
         can_bts_pkg::S_PRES_WAIT: begin
            if (div_rsp.done) begin
               if (!quo_usable) begin
                  state_in = can_bts_pkg::S_NEXT;
               end else if (div_rsp.remainder == '0) begin
                  state_in = can_bts_pkg::S_REPORT;
               end else begin
                  state_in = can_bts_pkg::S_CLK_GO;
               end
            end
         end
         can_bts_pkg::S_CLK_GO:     state_in = can_bts_pkg::S_CLK_WAIT;
         can_bts_pkg::S_CLK_WAIT: begin
            if (div_rsp.done) state_in = can_bts_pkg::S_ACT_GO;
         end
         can_bts_pkg::S_ACT_GO:     state_in = can_bts_pkg::S_ACT_WAIT;
         can_bts_pkg::S_ACT_WAIT: begin
            if (div_rsp.done) state_in = can_bts_pkg::S_NEXT;
         end
         can_bts_pkg::S_NEXT: begin
            state_in = (t_ff == TMin) ? can_bts_pkg::S_REPORT : can_bts_pkg::S_PRES_GO;
         end
         can_bts_pkg::S_REPORT:     state_in = can_bts_pkg::S_IDLE;
         default:                   state_in = can_bts_pkg::S_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      busy         = (state_ff != can_bts_pkg::S_IDLE);
      div_req      = '0;
      clk_in       = clk_ff;
      rate_in      = rate_ff;
      ratio_in     = ratio_ff;
      clkdiv_in    = clkdiv_ff;
      t_in         = t_ff;
      pres_in      = pres_ff;
      lowest_in    = lowest_ff;
      best_t_in    = best_t_ff;
      best_p_in    = best_p_ff;
      rsp_valid_in = 1'b0;
      result_in    = result_ff;
      case (state_ff)
         can_bts_pkg::S_IDLE: begin
            if (start) begin
               clk_in    = req_clock_hz;
               rate_in   = req_bit_rate;
               lowest_in = req_bit_rate;
               best_t_in = '0;
               best_p_in = '0;
               t_in      = TMax;
            end
         end
         can_bts_pkg::S_RATIO_GO: begin
            div_req.valid    = 1'b1;
            div_req.dividend = clk_ff;
            div_req.divisor  = VW'(rate_ff);
         end
         can_bts_pkg::S_RATIO_WAIT: begin
            if (div_rsp.done) ratio_in = div_rsp.quotient;
         end
         can_bts_pkg::S_PRES_GO: begin
            div_req.valid    = 1'b1;
            div_req.dividend = ratio_ff;
            div_req.divisor  = VW'(t_ff);
         end
         can_bts_pkg::S_PRES_WAIT: begin
            if (div_rsp.done && quo_usable) begin
               pres_in = div_rsp.quotient[PW-1:0];
               if (div_rsp.remainder == '0) begin
                  best_t_in = t_ff;
                  best_p_in = div_rsp.quotient[PW-1:0];
               end
            end
         end
         can_bts_pkg::S_CLK_GO: begin
            div_req.valid    = 1'b1;
            div_req.dividend = clk_ff;
            div_req.divisor  = VW'(pres_ff);
         end
         can_bts_pkg::S_CLK_WAIT: begin
            if (div_rsp.done) clkdiv_in = div_rsp.quotient;
         end
         can_bts_pkg::S_ACT_GO: begin
            div_req.valid    = 1'b1;
            div_req.dividend = clkdiv_ff;
            div_req.divisor  = VW'(t_ff);
         end
         can_bts_pkg::S_ACT_WAIT: begin
            // keep only a strictly nearer rate
            if (div_rsp.done && (actual_diff < DW'(lowest_ff))) begin
               lowest_in = actual_diff[RW-1:0];
               best_t_in = t_ff;
               best_p_in = pres_ff;
            end
         end
         can_bts_pkg::S_NEXT: begin
            if (t_ff != TMin) t_in = t_ff - QW'(1);
         end
         can_bts_pkg::S_REPORT: begin
            rsp_valid_in = 1'b1;
            result_in    = seg_result;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= can_bts_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // search registers and result fields
   always_ff @(posedge clock) begin
      clk_ff    <= clk_in;
      rate_ff   <= rate_in;
      ratio_ff  <= ratio_in;
      clkdiv_ff <= clkdiv_in;
      t_ff      <= t_in;
      pres_ff   <= pres_in;
      lowest_ff <= lowest_in;
      best_t_ff <= best_t_in;
      best_p_ff <= best_p_in;
      result_ff <= result_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = result_ff.status;
   assign rsp_prescaler_code   = result_ff.prescaler_code;
   assign rsp_jump_width_code  = result_ff.jump_width_code;
   assign rsp_phase_one_code   = result_ff.phase_one_code;
   assign rsp_phase_two_code   = result_ff.phase_two_code;
   assign rsp_propagation_code = result_ff.propagation_code;

endmodule

### tb/sv/can_bit_timing_solver_checker.sv
module can_bit_timing_solver_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_clock_hz,
   input  logic [19:0] req_bit_rate,
   input  logic        rsp_valid,
   input  logic        rsp_status,
   input  logic [7:0]  rsp_prescaler_code,
   input  logic [1:0]  rsp_jump_width_code,
   input  logic [2:0]  rsp_phase_one_code,
   input  logic [2:0]  rsp_phase_two_code,
   input  logic [2:0]  rsp_propagation_code,
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // timings predicted for accepted requests, oldest first
   can_bts_pkg::result_type pending_timings [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // segment length limited to 1..hi quanta
   function automatic int fit_len(input int len, input int hi);
      if (len < 1) return 1;
      if (len > hi) return hi;
      return len;
   endfunction

   // search quanta counts for the best prescaler and derive the segments
   function automatic can_bts_pkg::result_type solve_timing(input logic [31:0] clk_hz,
                                                            input logic [19:0] rate);
      can_bts_pkg::result_type res;
      logic [31:0] ratio;
      logic [31:0] nearest;
      logic [31:0] pres;
      logic [31:0] achieved;
      logic [31:0] gap;
      int          best_t;
      int          best_p;
      int          tq;
      int          span;
      int          ph1;
      int          ph2;
      int          prop;
      int          sjw;
      res = '0;
      res.status = 1'b1;
      if (rate == '0) return res;
      ratio = clk_hz / 32'(rate);
      if (ratio < 32'(can_bts_pkg::DEF_MIN_QUANTA - 1)) return res;

      // largest count first; exact fit ends the search
      nearest = 32'(rate);
      best_t  = 0;
      best_p  = 0;
      for (tq = can_bts_pkg::DEF_MAX_QUANTA; tq >= can_bts_pkg::DEF_MIN_QUANTA; tq--) begin
         pres = ratio / 32'(tq);
         if (pres == '0 || pres > can_bts_pkg::PRESCALE_LIMIT) continue;
         if (64'(tq) * 64'(pres) == 64'(ratio)) begin
            best_t = tq;
            best_p = int'(pres);
            break;
         end
         achieved = (clk_hz / pres) / 32'(tq);
         gap = (achieved > 32'(rate)) ? achieved - 32'(rate) : 32'(rate) - achieved;
         if (gap < nearest) begin
            nearest = gap;
            best_t  = tq;
            best_p  = int'(pres);
         end
      end
      if (best_t == 0 || best_p == 0) return res;

      // segment split of the chosen count
      span = best_t - can_bts_pkg::DEF_MAX_PROP_SEG;
      if (span < 0) span = 0;
      ph2 = span / 2;
      if (ph2 < can_bts_pkg::DEF_MIN_PHASE_TWO) ph2 = can_bts_pkg::DEF_MIN_PHASE_TWO;
      ph1  = (best_t == can_bts_pkg::DEF_MIN_QUANTA) ? 1 : ph2;
      prop = best_t - ph1 - ph2 - 1;
      sjw  = (ph1 < can_bts_pkg::DEF_MAX_JUMP_WIDTH) ? ph1 : can_bts_pkg::DEF_MAX_JUMP_WIDTH;

      res.status           = 1'b0;
      res.prescaler_code   = 8'(best_p - 1);
      res.jump_width_code  = 2'(fit_len(sjw, 4) - 1);
      res.phase_one_code   = 3'(fit_len(ph1, 8) - 1);
      res.phase_two_code   = 3'(fit_len(ph2, 8) - 1);
      res.propagation_code = 3'(fit_len(prop, 8) - 1);
      return res;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // compare each result transfer, then record each request transfer
   always @(posedge clock) begin
      can_bts_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_timings.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d prescaler %0d",
                        $time, rsp_status, rsp_prescaler_code);
               mismatches++;
            end else begin
               want = pending_timings.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("prescaler_code", want.prescaler_code, rsp_prescaler_code);
               check_field("jump_width_code", want.jump_width_code, rsp_jump_width_code);
               check_field("phase_one_code", want.phase_one_code, rsp_phase_one_code);
               check_field("phase_two_code", want.phase_two_code, rsp_phase_two_code);
               check_field("propagation_code", want.propagation_code,
                           rsp_propagation_code);
            end
         end
         if (start && !busy)
            pending_timings.push_back(solve_timing(req_clock_hz, req_bit_rate));
      end
      outstanding <= pending_timings.size();
   end

endmodule

### tb/sv/can_bit_timing_solver_tb.sv
module can_bit_timing_solver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        start        = 1'b0;
   logic [31:0] req_clock_hz = '0;
   logic [19:0] req_bit_rate = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_status;
   logic [7:0]  rsp_prescaler_code;
   logic [1:0]  rsp_jump_width_code;
   logic [2:0]  rsp_phase_one_code;
   logic [2:0]  rsp_phase_two_code;
   logic [2:0]  rsp_propagation_code;
   int          mismatches;
   int          outstanding;

   // gap-free stretch length still to run
   int          calm_left = 0;

   int unsigned common_rates [10] = '{10000, 20000, 50000, 83333, 100000,
                                      125000, 250000, 500000, 800000, 1000000};
   int unsigned common_clocks [8] = '{8000000, 16000000, 20000000, 24000000,
                                      40000000, 48000000, 60000000, 80000000};

   can_bit_timing_solver u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_clock_hz         (req_clock_hz),
      .req_bit_rate         (req_bit_rate),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_prescaler_code   (rsp_prescaler_code),
      .rsp_jump_width_code  (rsp_jump_width_code),
      .rsp_phase_one_code   (rsp_phase_one_code),
      .rsp_phase_two_code   (rsp_phase_two_code),
      .rsp_propagation_code (rsp_propagation_code)
   );

   can_bit_timing_solver_checker u_check (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_clock_hz         (req_clock_hz),
      .req_bit_rate         (req_bit_rate),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_prescaler_code   (rsp_prescaler_code),
      .rsp_jump_width_code  (rsp_jump_width_code),
      .rsp_phase_one_code   (rsp_phase_one_code),
      .rsp_phase_two_code   (rsp_phase_two_code),
      .rsp_propagation_code (rsp_propagation_code),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one request transfer, after a random idle gap; called right after an edge
   task automatic send_request(input logic [31:0] clk_hz, input logic [19:0] rate);
      int unsigned roll;
      int unsigned idle;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         idle = 0;
         calm_left--;
      end else if (roll < 40) idle = 0;
      else if (roll < 80) idle = $urandom_range(1, 5);
      else if (roll < 95) idle = $urandom_range(6, 200);
      else idle = $urandom_range(200, 2500);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start        <= 1'b1;
      req_clock_hz <= clk_hz;
      req_bit_rate <= rate;
      do @(posedge clock); while (busy);
   endtask

   // stimulus
   initial begin
      int unsigned     roll;
      int unsigned     ratio;
      longint unsigned wide;
      logic [19:0]     rate;
      logic [31:0]     clk_hz;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: error paths, quanta and prescaler extremes, field extremes
      send_request(32'd16000000, 20'd0);
      send_request(32'd6, 20'd1);
      send_request(32'd7, 20'd1);
      send_request(32'd8, 20'd1);
      send_request(32'd9, 20'd1);
      send_request(32'd17, 20'd1);
      send_request(32'd25, 20'd1);
      send_request(32'd1, 20'd1);
      send_request(32'd0, 20'd1000000);
      send_request(32'd16000000, 20'd500000);
      send_request(32'd80000000, 20'd1000000);
      send_request(32'd24000000, 20'd125000);
      send_request(32'hFFFFFFFF, 20'd1);
      send_request(32'hFFFFFFFF, 20'd1000000);
      send_request(32'hFFFFFFFF, 20'hFFFFF);
      send_request(32'd6400, 20'd1);
      send_request(32'd6424, 20'd1);
      send_request(32'd6425, 20'd1);
      send_request(32'd1000003, 20'd100000);
      send_request(32'd12345678, 20'd83333);
      send_request(32'h80000000, 20'h80000);
      send_request(32'd20000000, 20'd33333);

      // random: clocks near a multiple of the rate, common clocks, random clocks and small clocks
      for (int n = 0; n < 300; n++) begin
         if (n % 60 == 30) calm_left = 20;
         roll = $urandom_range(0, 99);
         if (roll < 50) rate = 20'(common_rates[$urandom_range(0, 9)]);
         else if (roll < 90) rate = 20'($urandom_range(1, 1000000));
         else rate = 20'($urandom_range(1, 20'hFFFFF));

         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            ratio = $urandom_range(7, 6500);
            wide  = longint'(ratio) * longint'(rate);
            if (wide != 0 && $urandom_range(0, 1) == 1)
               wide += $urandom_range(0, int'(rate) - 1);
            clk_hz = (wide > 64'hFFFFFFFF) ? $urandom : 32'(wide);
         end else if (roll < 60) clk_hz = common_clocks[$urandom_range(0, 7)];
         else if (roll < 90) clk_hz = $urandom;
         else clk_hz = $urandom_range(0, 200);
         send_request(clk_hz, rate);
      end
      start <= 1'b0;

      // drain, then allow the last result to settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // run limit
   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
